[sv/hwt_pkg.sv]
package hwt_pkg;

    // Wheel geometry.
    localparam int ROOT_BITS   = 8;
    localparam int LEVEL_BITS  = 6;
    localparam int LEVEL_COUNT = 4;
    localparam int TIMER_COUNT = 64;

    localparam int ROOT_SIZE  = 1 << ROOT_BITS;
    localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
    localparam int SLOT_COUNT = ROOT_SIZE + LEVEL_COUNT * LEVEL_SIZE;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

    // Field and pointer widths.
    localparam int ID_BITS       = 6;
    localparam int PTR_BITS      = ID_BITS + 1;
    localparam int LVL_BITS      = $clog2(LEVEL_COUNT + 1);
    localparam int CNT_BITS      = $clog2(TIMER_COUNT + 1);
    localparam int TICK_BITS     = 33;
    localparam int DIV_CNT_BITS  = $clog2(TICK_BITS);

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [ID_BITS-1:0]   id_t;
    typedef logic [PTR_BITS-1:0]  ptr_t;
    typedef logic [LVL_BITS-1:0]  lvl_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    localparam ptr_t NIL = '1;

    // Command codes.
    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_DEL = 2'd1;
    localparam logic [1:0] CMD_ADV = 2'd2;

    // Result kinds.
    localparam logic KIND_DEL = 1'b0;
    localparam logic KIND_EXP = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TICK_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_START_TIME    = 2'd1;

    // A list pointer that names a real timer.
    function automatic logic ptr_ok(ptr_t p);
        return (32'(p) < TIMER_COUNT);
    endfunction

    // Wheel that a slot belongs to: 0 is the root wheel.
    function automatic lvl_t level_of(slot_t s);
        if (s < slot_t'(ROOT_SIZE)) begin
            return '0;
        end
        return lvl_t'(((s - slot_t'(ROOT_SIZE)) >> LEVEL_BITS) + 1);
    endfunction

    // Index of a tick value within cascade wheel i.
    function automatic logic [LEVEL_BITS-1:0] level_index(logic [31:0] v, int i);
        logic [63:0] w;
        w = {32'd0, v} >> (ROOT_BITS + i * LEVEL_BITS);
        return w[LEVEL_BITS-1:0];
    endfunction

    // Slot that a timer with expiry e goes into at tick ct.
    function automatic slot_t place_slot(logic [31:0] e, logic [31:0] ct);
        logic [31:0] d;
        logic [63:0] d64;
        logic [63:0] top;
        logic [31:0] park;
        slot_t       r;
        d    = e - ct;
        d64  = {32'd0, d};
        top  = 64'd1 << (ROOT_BITS + LEVEL_COUNT * LEVEL_BITS);
        park = ct + 32'(top - 64'd1);
        // Beyond the top wheel span the timer is parked and placed again later.
        r = slot_t'(ROOT_SIZE + (LEVEL_COUNT - 1) * LEVEL_SIZE)
            + slot_t'(level_index(park, LEVEL_COUNT - 1));
        for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            if ((d64 >> (ROOT_BITS + (i + 1) * LEVEL_BITS)) == 64'd0) begin
                r = slot_t'(ROOT_SIZE + i * LEVEL_SIZE) + slot_t'(level_index(e, i));
            end
        end
        if (d < 32'(ROOT_SIZE)) begin
            r = slot_t'(e[ROOT_BITS-1:0]);
        end
        return r;
    endfunction

    // Index of the current tick within cascade wheel l.
    function automatic logic [LEVEL_BITS-1:0] casc_index(logic [31:0] ct, lvl_t l);
        logic [LEVEL_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            if (l == lvl_t'(i)) begin
                r = level_index(ct, i);
            end
        end
        return r;
    endfunction

    // Cascade wheel slot that is due when wheel l cascades at tick ct.
    function automatic slot_t casc_slot(logic [31:0] ct, lvl_t l);
        slot_t r;
        r = '0;
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            if (l == lvl_t'(i)) begin
                r = slot_t'(ROOT_SIZE + i * LEVEL_SIZE) + slot_t'(level_index(ct, i));
            end
        end
        return r;
    endfunction

    // Ticks until the next boundary of wheel k (k from 1).
    function automatic logic [TICK_BITS-1:0] dist_of(lvl_t k, logic [31:0] ct);
        logic [TICK_BITS-1:0] unit;
        logic [TICK_BITS-1:0] r;
        r = '0;
        for (int i = 1; i <= LEVEL_COUNT; i++) begin
            if (k == lvl_t'(i)) begin
                unit = 33'd1 << (((ROOT_BITS + (i - 1) * LEVEL_BITS) > 32) ? 32
                                 : (ROOT_BITS + (i - 1) * LEVEL_BITS));
                r = unit - ({1'b0, ct} & (unit - 33'd1));
            end
        end
        return r;
    endfunction

endpackage

[sv/hierarchical_timer_wheel_unit.sv]
// Channel   Handshake               Payload
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
// req       req_valid / req_ready   cmd, timer_id, delay_ticks, notify, now_time
// res       res_valid / res_ready   kind, timer_id_res, was_pending, last
//
// One request is worked at a time by a sequencer around list memories with one read and one write port each.
// An advance to a time not above the last one does no work; otherwise the elapsed time
// is divided by the tick interval, then the ticks are run, cascade slots are visited and
// timers are moved or expired.
// After reset a clearing pass empties all 512 slot heads; req_ready is low then.
// A result waiting on res_ready holds the sequencer only when it needs the output register.
module hierarchical_timer_wheel_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           cmd,
    input  hwt_pkg::id_t         timer_id,
    input  logic [31:0]          delay_ticks,
    input  logic                 notify,
    input  logic [63:0]          now_time,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 kind,
    output hwt_pkg::id_t         timer_id_res,
    output logic                 was_pending,
    output logic                 last
);
    import hwt_pkg::*;

    typedef enum logic [25:0] {
        S_CLEAR = 26'h0000001,
        S_IDLE  = 26'h0000002,
        S_ADD   = 26'h0000004,
        S_DEL   = 26'h0000008,
        S_ADV   = 26'h0000010,
        S_DIV   = 26'h0000020,
        S_RUN   = 26'h0000040,
        S_STEP  = 26'h0000080,
        S_TICK  = 26'h0000100,
        S_TCHK  = 26'h0000200,
        S_C0    = 26'h0000400,
        S_C1    = 26'h0000800,
        S_C2    = 26'h0001000,
        S_C3    = 26'h0002000,
        S_CNEXT = 26'h0004000,
        S_E0    = 26'h0008000,
        S_E1    = 26'h0010000,
        S_U0    = 26'h0020000,
        S_U1    = 26'h0040000,
        S_RPT   = 26'h0080000,
        S_PLACE = 26'h0100000,
        S_A0    = 26'h0200000,
        S_A1    = 26'h0400000,
        S_A2    = 26'h0800000,
        S_DREP  = 26'h1000000,
        S_FIN   = 26'h2000000
    } state_t;

    // Control state.
    state_t                 state_reg, state_next;
    slot_t                  clr_cnt_reg, clr_cnt_next;
    logic [15:0]            tick_reg, tick_next;
    logic [63:0]            last_time_reg, last_time_next;
    logic [31:0]            ct_reg, ct_next;
    logic [15:0]            time_rem_reg, time_rem_next;
    logic [TIMER_COUNT-1:0] armed_reg, armed_next;
    cnt_t                   cnt_reg [LEVEL_COUNT+1];
    cnt_t                   cnt_next [LEVEL_COUNT+1];
    logic                   res_valid_reg, res_valid_next;
    logic                   pend_valid_reg, pend_valid_next;

    // Work registers.
    logic [1:0]             op_reg, op_next;
    id_t                    cur_id_reg, cur_id_next;
    logic [31:0]            delay_reg, delay_next;
    logic                   nfy_reg, nfy_next;
    logic [63:0]            now_reg, now_next;
    logic                   was_reg, was_next;
    logic [31:0]            e_reg, e_next;
    ptr_t                   nx_reg, nx_next;
    ptr_t                   t_reg, t_next;
    slot_t                  slot_reg, slot_next;
    slot_t                  casc_slot_reg, casc_slot_next;
    lvl_t                   casc_lvl_reg, casc_lvl_next;
    logic [TICK_BITS-1:0]   ticks_reg, ticks_next;
    logic [TICK_BITS-1:0]   dist_reg, dist_next;
    logic [15:0]            div_rem_reg, div_rem_next;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg, div_cnt_next;
    id_t                    pend_id_reg, pend_id_next;
    logic                   kind_reg, kind_next;
    id_t                    id_res_reg, id_res_next;
    logic                   was_res_reg, was_res_next;
    logic                   last_reg, last_next;

    // Memories and their ports.
    ptr_t        head_mem [SLOT_COUNT];
    ptr_t        tail_mem [SLOT_COUNT];
    ptr_t        next_mem [TIMER_COUNT];
    ptr_t        prev_mem [TIMER_COUNT];
    slot_t       slotm_mem [TIMER_COUNT];
    logic [31:0] exp_mem [TIMER_COUNT];
    logic        nfy_mem [TIMER_COUNT];

    ptr_t        head_rd, tail_rd, next_rd, prev_rd;
    slot_t       slotm_rd;
    logic [31:0] exp_rd;
    logic        nfy_rd;

    slot_t       slot_raddr;
    logic        head_we, tail_we, next_we, prev_we, slotm_we, exp_we, nfy_we;
    slot_t       head_waddr, tail_waddr;
    ptr_t        head_wdata, tail_wdata, next_wdata, prev_wdata;
    id_t         next_waddr, prev_waddr;
    logic [31:0] exp_wdata;

    // Helpers.
    logic                   out_free;
    logic [15:0]            iv;
    logic [16:0]            div_shift;
    logic                   div_ge;
    logic [16:0]            div_diff;
    logic                   lvl_found;
    lvl_t                   first_lvl;
    logic                   cnt_inc, cnt_dec;
    lvl_t                   cnt_lvl;
    state_t                 app_done_state;
    ptr_t                   app_t;
    logic                   in_pool;
    logic [31:0]            add_exp;

    assign cfg_ready    = 1'b1;
    assign req_ready    = (state_reg == S_IDLE);
    assign res_valid    = res_valid_reg;
    assign kind         = kind_reg;
    assign timer_id_res = id_res_reg;
    assign was_pending  = was_res_reg;
    assign last         = last_reg;

    assign out_free  = !res_valid_reg || res_ready;
    assign iv        = (tick_reg == 16'd0) ? 16'd1 : tick_reg;
    assign div_shift = {div_rem_reg, ticks_reg[TICK_BITS-1]};
    assign div_ge    = (div_shift >= {1'b0, iv});
    assign div_diff  = div_shift - {1'b0, iv};
    assign in_pool   = (32'(cur_id_reg) < TIMER_COUNT);
    assign add_exp   = ct_reg + ((delay_reg == 32'd0) ? 32'd1 : delay_reg);
    assign app_t     = (head_rd == NIL) ? NIL : tail_rd;

    // Lowest wheel that holds any timer.
    always_comb
    begin
        lvl_found = 1'b0;
        first_lvl = '0;
        for (int i = LEVEL_COUNT; i >= 0; i--) begin
            if (cnt_reg[i] != '0)
            begin
                lvl_found = 1'b1;
                first_lvl = lvl_t'(i);
            end
        end
    end

    // Where an append returns: adds finish, cascades walk on.
    always_comb
    begin
        if (op_reg == CMD_ADD)
        begin
            app_done_state = S_IDLE;
        end
        else if (ptr_ok(nx_reg))
        begin
            app_done_state = S_C2;
        end
        else
        begin
            app_done_state = S_CNEXT;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        tick_next       = tick_reg;
        last_time_next  = last_time_reg;
        ct_next         = ct_reg;
        time_rem_next   = time_rem_reg;
        armed_next      = armed_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        pend_valid_next = pend_valid_reg;
        op_next         = op_reg;
        cur_id_next     = cur_id_reg;
        delay_next      = delay_reg;
        nfy_next        = nfy_reg;
        now_next        = now_reg;
        was_next        = was_reg;
        e_next          = e_reg;
        nx_next         = nx_reg;
        t_next          = t_reg;
        slot_next       = slot_reg;
        casc_slot_next  = casc_slot_reg;
        casc_lvl_next   = casc_lvl_reg;
        ticks_next      = ticks_reg;
        dist_next       = dist_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        pend_id_next    = pend_id_reg;
        kind_next       = kind_reg;
        id_res_next     = id_res_reg;
        was_res_next    = was_res_reg;
        last_next       = last_reg;

        slot_raddr = slot_reg;
        head_we    = 1'b0;
        head_waddr = slot_reg;
        head_wdata = NIL;
        tail_we    = 1'b0;
        tail_waddr = slot_reg;
        tail_wdata = NIL;
        next_we    = 1'b0;
        next_waddr = cur_id_reg;
        next_wdata = NIL;
        prev_we    = 1'b0;
        prev_waddr = cur_id_reg;
        prev_wdata = NIL;
        slotm_we   = 1'b0;
        exp_we     = 1'b0;
        exp_wdata  = add_exp;
        nfy_we     = 1'b0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        cnt_lvl    = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                head_we      = 1'b1;
                head_waddr   = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + slot_t'(1);
                if (clr_cnt_reg == slot_t'(SLOT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = cmd;
                    cur_id_next = timer_id;
                    delay_next  = delay_ticks;
                    nfy_next    = notify;
                    now_next    = now_time;
                    unique case (cmd)
                        CMD_ADD: state_next = S_ADD;
                        CMD_DEL: state_next = S_DEL;
                        CMD_ADV: state_next = S_ADV;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            // Write the new expiry; a pending timer is unlinked before placing.
            S_ADD:
            begin
                if (in_pool)
                begin
                    e_next                 = add_exp;
                    exp_we                 = 1'b1;
                    nfy_we                 = 1'b1;
                    armed_next[cur_id_reg] = 1'b1;
                    state_next = armed_reg[cur_id_reg] ? S_U0 : S_PLACE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DEL:
            begin
                if (in_pool && armed_reg[cur_id_reg])
                begin
                    armed_next[cur_id_reg] = 1'b0;
                    was_next               = 1'b1;
                    state_next             = S_U0;
                end
                else
                begin
                    was_next   = 1'b0;
                    state_next = S_DREP;
                end
            end
            // Elapsed time plus carried remainder, then divide by the interval.
            S_ADV:
            begin
                if (now_reg > last_time_reg)
                begin
                    last_time_next = now_reg;
                    ticks_next     = {1'b0, now_reg[31:0] - last_time_reg[31:0]}
                                     + {17'd0, time_rem_reg};
                    div_rem_next   = '0;
                    div_cnt_next   = DIV_CNT_BITS'(TICK_BITS - 1);
                    state_next     = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            // Restoring divider, one quotient bit a cycle.
            S_DIV:
            begin
                if (div_ge)
                begin
                    div_rem_next = div_diff[15:0];
                    ticks_next   = {ticks_reg[TICK_BITS-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = div_shift[15:0];
                    ticks_next   = {ticks_reg[TICK_BITS-2:0], 1'b0};
                end
                if (div_cnt_reg == '0)
                begin
                    time_rem_next = div_rem_next;
                    state_next    = S_RUN;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - DIV_CNT_BITS'(1);
                end
            end
            // Skip ticks that cannot change anything.
            S_RUN:
            begin
                if (ticks_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (!lvl_found)
                begin
                    ct_next    = ct_reg + ticks_reg[31:0];
                    ticks_next = '0;
                    state_next = S_FIN;
                end
                else if (first_lvl == '0)
                begin
                    state_next = S_TICK;
                end
                else
                begin
                    dist_next  = dist_of(first_lvl, ct_reg);
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (dist_reg > ticks_reg)
                begin
                    ct_next    = ct_reg + ticks_reg[31:0];
                    ticks_next = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    ct_next    = ct_reg + dist_reg[31:0] - 32'd1;
                    ticks_next = ticks_reg - dist_reg + 33'd1;
                    state_next = S_TICK;
                end
            end
            S_TICK:
            begin
                ct_next       = ct_reg + 32'd1;
                ticks_next    = ticks_reg - 33'd1;
                casc_lvl_next = '0;
                state_next    = S_TCHK;
            end
            // Root wrap: cascade the due slot of each wheel in turn, going up only while the wheel's index is zero.
            S_TCHK:
            begin
                if (ct_reg[ROOT_BITS-1:0] == '0)
                begin
                    casc_slot_next = casc_slot(ct_reg, casc_lvl_reg);
                    state_next     = S_C0;
                end
                else
                begin
                    state_next = S_E0;
                end
            end
            S_C0:
            begin
                slot_raddr = casc_slot_reg;
                state_next = S_C1;
            end
            S_C1:
            begin
                head_we    = 1'b1;
                head_waddr = casc_slot_reg;
                if (ptr_ok(head_rd))
                begin
                    cur_id_next = head_rd[ID_BITS-1:0];
                    state_next  = S_C2;
                end
                else
                begin
                    state_next = S_CNEXT;
                end
            end
            S_C2:
            begin
                state_next = S_C3;
            end
            S_C3:
            begin
                e_next     = exp_rd;
                nx_next    = next_rd;
                cnt_dec    = 1'b1;
                cnt_lvl    = level_of(casc_slot_reg);
                state_next = S_PLACE;
            end
            S_CNEXT:
            begin
                if (casc_index(ct_reg, casc_lvl_reg) != '0
                    || casc_lvl_reg == lvl_t'(LEVEL_COUNT - 1))
                begin
                    state_next = S_E0;
                end
                else
                begin
                    casc_lvl_next = casc_lvl_reg + lvl_t'(1);
                    state_next    = S_TCHK;
                end
            end
            // Expire the root slot from its head.
            S_E0:
            begin
                slot_raddr = slot_t'(ct_reg[ROOT_BITS-1:0]);
                state_next = S_E1;
            end
            S_E1:
            begin
                if (ptr_ok(head_rd))
                begin
                    cur_id_next                        = head_rd[ID_BITS-1:0];
                    armed_next[head_rd[ID_BITS-1:0]]   = 1'b0;
                    state_next                         = S_U0;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            // Unlink: read the links, then patch neighbors or the slot ends.
            S_U0:
            begin
                state_next = S_U1;
            end
            S_U1:
            begin
                if (prev_rd == NIL)
                begin
                    head_we    = 1'b1;
                    head_waddr = slotm_rd;
                    head_wdata = next_rd;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd[ID_BITS-1:0];
                    next_wdata = next_rd;
                end
                if (next_rd == NIL)
                begin
                    tail_we    = 1'b1;
                    tail_waddr = slotm_rd;
                    tail_wdata = prev_rd;
                end
                else
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rd[ID_BITS-1:0];
                    prev_wdata = prev_rd;
                end
                cnt_dec = 1'b1;
                cnt_lvl = level_of(slotm_rd);
                unique case (op_reg)
                    CMD_ADD: state_next = S_PLACE;
                    CMD_DEL: state_next = S_DREP;
                    default:
                    begin
                        nfy_next   = nfy_rd;
                        state_next = S_RPT;
                    end
                endcase
            end
            // Expiries are held back one so the final one can carry last.
            S_RPT:
            begin
                if (!nfy_reg)
                begin
                    state_next = S_E0;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        kind_next      = KIND_EXP;
                        id_res_next    = pend_id_reg;
                        was_res_next   = 1'b0;
                        last_next      = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = cur_id_reg;
                    state_next      = S_E0;
                end
            end
            S_PLACE:
            begin
                slot_next  = place_slot(e_reg, ct_reg);
                state_next = S_A0;
            end
            // Append at the tail of the chosen slot.
            S_A0:
            begin
                slot_raddr = slot_reg;
                state_next = S_A1;
            end
            S_A1:
            begin
                prev_we    = 1'b1;
                prev_wdata = app_t;
                next_we    = 1'b1;
                slotm_we   = 1'b1;
                tail_we    = 1'b1;
                tail_wdata = {1'b0, cur_id_reg};
                if (app_t == NIL)
                begin
                    head_we    = 1'b1;
                    head_wdata = {1'b0, cur_id_reg};
                end
                t_next  = app_t;
                cnt_inc = 1'b1;
                cnt_lvl = level_of(slot_reg);
                if (app_t != NIL)
                begin
                    state_next = S_A2;
                end
                else
                begin
                    state_next = app_done_state;
                    if (app_done_state == S_C2)
                    begin
                        cur_id_next = nx_reg[ID_BITS-1:0];
                    end
                end
            end
            S_A2:
            begin
                next_we    = 1'b1;
                next_waddr = t_reg[ID_BITS-1:0];
                next_wdata = {1'b0, cur_id_reg};
                state_next = app_done_state;
                if (app_done_state == S_C2)
                begin
                    cur_id_next = nx_reg[ID_BITS-1:0];
                end
            end
            S_DREP:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = KIND_DEL;
                    id_res_next    = cur_id_reg;
                    was_res_next   = was_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    kind_next       = KIND_EXP;
                    id_res_next     = pend_id_reg;
                    was_res_next    = 1'b0;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Per-wheel timer counts.
        for (int i = 0; i <= LEVEL_COUNT; i++) begin
            cnt_next[i] = cnt_reg[i];
            if (cnt_inc && cnt_lvl == lvl_t'(i))
            begin
                cnt_next[i] = cnt_reg[i] + cnt_t'(1);
            end
            if (cnt_dec && cnt_lvl == lvl_t'(i))
            begin
                cnt_next[i] = cnt_reg[i] - cnt_t'(1);
            end
        end

        // Configuration writes.
        if (cfg_valid)
        begin
            if (cfg_index == CFG_TICK_INTERVAL)
            begin
                tick_next = cfg_data[15:0];
            end
            else if (cfg_index == CFG_START_TIME)
            begin
                last_time_next = cfg_data;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            tick_reg       <= 16'd1;
            last_time_reg  <= '0;
            ct_reg         <= '0;
            time_rem_reg   <= '0;
            armed_reg      <= '0;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i <= LEVEL_COUNT; i++) begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            tick_reg       <= tick_next;
            last_time_reg  <= last_time_next;
            ct_reg         <= ct_next;
            time_rem_reg   <= time_rem_next;
            armed_reg      <= armed_next;
            res_valid_reg  <= res_valid_next;
            pend_valid_reg <= pend_valid_next;
            for (int i = 0; i <= LEVEL_COUNT; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // Work and payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        cur_id_reg    <= cur_id_next;
        delay_reg     <= delay_next;
        nfy_reg       <= nfy_next;
        now_reg       <= now_next;
        was_reg       <= was_next;
        e_reg         <= e_next;
        nx_reg        <= nx_next;
        t_reg         <= t_next;
        slot_reg      <= slot_next;
        casc_slot_reg <= casc_slot_next;
        casc_lvl_reg  <= casc_lvl_next;
        ticks_reg     <= ticks_next;
        dist_reg      <= dist_next;
        div_rem_reg   <= div_rem_next;
        div_cnt_reg   <= div_cnt_next;
        pend_id_reg   <= pend_id_next;
        kind_reg      <= kind_next;
        id_res_reg    <= id_res_next;
        was_res_reg   <= was_res_next;
        last_reg      <= last_next;
    end

    // Slot head and tail memories, read at one shared address.
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rd <= head_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tail_we)
        begin
            tail_mem[tail_waddr] <= tail_wdata;
        end
        tail_rd <= tail_mem[slot_raddr];
    end

    // Per-timer memories, read at the timer being worked on.
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rd <= next_mem[cur_id_reg];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_rd <= prev_mem[cur_id_reg];
    end

    always_ff @(posedge clk)
    begin
        if (slotm_we)
        begin
            slotm_mem[cur_id_reg] <= slot_reg;
        end
        slotm_rd <= slotm_mem[cur_id_reg];
    end

    always_ff @(posedge clk)
    begin
        if (exp_we)
        begin
            exp_mem[cur_id_reg] <= exp_wdata;
        end
        exp_rd <= exp_mem[cur_id_reg];
    end

    always_ff @(posedge clk)
    begin
        if (nfy_we)
        begin
            nfy_mem[cur_id_reg] <= nfy_reg;
        end
        nfy_rd <= nfy_mem[cur_id_reg];
    end

endmodule
